// ----- sv/ine_pkg.sv -----
// ----------------------------------------------------------------------------
// ine_pkg
// Types shared by the erosion unit and its pass engine.
// ----------------------------------------------------------------------------
package ine_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_ROW,
    ST_SCAN,
    ST_NEXT,
    ST_DONE
  } state_t;

  // register indexes, in the order of the register map
  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic busy;
  } eng_ctl_t;

endpackage

// ----- sv/ine_engine.sv -----
// ----------------------------------------------------------------------------
// ine_engine
// Pass sequencer: copies each row into the two-row window, scans its cells
// against three rows and writes removals back to the cell memory.
// ----------------------------------------------------------------------------
module ine_engine import ine_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  eng_ctl_t                              ctl_in,
  output logic                                  busy,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h,
  input  logic [3:0]                            thr,
  input  logic                                  ld_we,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ld_addr,
  input  logic                                  ld_bit,
  output logic [16:0]                           tally
);
  localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT) > 0 ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1;
  localparam int XW = $clog2(MAX_WIDTH+1);
  localparam int YW = $clog2(MAX_HEIGHT+1);
  localparam int XI = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;

  state_t state, state_next;
  logic mem [2**AW];
  logic win [2][MAX_WIDTH];
  logic [XW-1:0] x;       // column of current issue
  logic [YW-1:0] y;
  logic [AW-1:0] rbase;   // y*w
  logic changed;
  logic rd_v, rd_vd;      // read issued last cycle / rd_v registered once more
  logic [XW-1:0] rx, rxd;
  logic rdat;
  logic cur_bit, prev_bit; // window cells of the column issued last cycle
  // scan shift regs: three rows, left/centre/right
  logic [2:0] sp, sc, sn;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (ctl_in.start) state_next = ST_START;
      ST_START: state_next = ST_ROW;
      ST_ROW:   if (!rd_v && !rd_vd && x == w) state_next = ST_SCAN;
      ST_SCAN:  if (!rd_v && !rd_vd && x == w) state_next = ST_NEXT;
      ST_NEXT:  if (y + YW'(1) < h) state_next = ST_ROW;
                else if (changed) state_next = ST_START;
                else state_next = ST_DONE;
      ST_DONE:  state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  assign busy = (state != ST_LOAD);

  // read address: row copy reads current row, scan reads next row
  logic issue;
  logic [AW-1:0] raddr;
  assign issue = (state == ST_ROW || state == ST_SCAN) && x < w;
  always_comb begin
    raddr = rbase + AW'(x);
    if (state == ST_SCAN) raddr = rbase + AW'(w) + AW'(x);
  end

  logic cy;
  assign cy = y[0];
  logic [XI-1:0] wx;      // window column of the returning read
  assign wx = rx[XI-1:0];
  logic [XI-1:0] ix;      // window column of the issue
  assign ix = x[XI-1:0];

  // centre cell being decided is column rxd-1 in scan
  logic [3:0] cnt;
  logic remove;
  logic has_next;
  assign has_next = (y + YW'(1) < h);
  always_comb begin
    cnt = 4'(sp[0]) + 4'(sp[1]) + 4'(sp[2]) + 4'(sc[0]) + 4'(sc[2])
        + 4'(sn[0]) + 4'(sn[1]) + 4'(sn[2]);
    remove = sc[1] && (cnt < thr);
  end

  logic scan_fire;   // a centre is ready: column rxd-1 (or w-1 at the flush)
  logic [XW-1:0] dcol;
  logic flush;
  logic row_end;     // last column of the row is in the decide stage
  assign row_end = (state == ST_SCAN && rd_vd && rxd + XW'(1) == w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      rd_v <= 1'b0; rd_vd <= 1'b0;
      x <= '0; y <= '0; rbase <= '0; changed <= 1'b0; tally <= '0;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      rd_v <= issue; rd_vd <= rd_v;
      rx <= x; rxd <= rx;
      if (state == ST_START || state == ST_NEXT ||
          (state == ST_ROW && state_next == ST_SCAN)) begin
        x <= '0;
      end else if (issue) begin
        x <= x + XW'(1);
      end
      if (state == ST_START || (state == ST_NEXT && state_next == ST_START)) begin
        y <= '0; rbase <= '0;
      end else if (state == ST_NEXT) begin
        y <= y + YW'(1);
        rbase <= rbase + AW'(w);
      end
      if (state == ST_START) changed <= 1'b0;
      else if (scan_fire && remove) changed <= 1'b1;
      if (state == ST_LOAD && ctl_in.start) tally <= '0;
      else if (scan_fire && remove) tally <= tally + 17'd1;
      flush <= row_end;
    end
  end

  // window and scan pipeline
  logic wv, nv_in, pv_in;
  always_comb begin
    wv = cur_bit;
    pv_in = (y != '0) ? prev_bit : 1'b0;
    nv_in = has_next ? rdat : 1'b0;
  end
  assign scan_fire = (state == ST_SCAN && rd_vd && rxd != '0) || flush;
  assign dcol = flush ? w - XW'(1) : rxd - XW'(1);

  always_ff @(posedge clk) begin
    if (state == ST_ROW && rd_v) win[cy][wx] <= rdat;
    if (state == ST_SCAN && issue) begin
      cur_bit  <= win[cy][ix];
      prev_bit <= win[~cy][ix];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && rd_v) begin
      if (rx == '0) begin
        sp <= {pv_in, 2'b00}; sc <= {wv, 2'b00}; sn <= {nv_in, 2'b00};
      end else begin
        sp <= {pv_in, sp[2:1]}; sc <= {wv, sc[2:1]}; sn <= {nv_in, sn[2:1]};
      end
    end else if (row_end) begin
      sp <= {1'b0, sp[2:1]}; sc <= {1'b0, sc[2:1]}; sn <= {1'b0, sn[2:1]};
    end
  end

  // cell memory: one write port (load or removal), one read port
  always_ff @(posedge clk) begin
    if (ld_we) mem[ld_addr] <= ld_bit;
    else if (scan_fire && remove) mem[rbase + AW'(dcol)] <= 1'b0;
    rdat <= mem[raddr];
  end

  assert property (@(posedge clk) disable iff (rst) ld_we |-> state == ST_LOAD)
    else $error("load write during pass");
  assert property (@(posedge clk) disable iff (rst) issue |-> x < w)
    else $error("read beyond row");
  assert property (@(posedge clk) disable iff (rst)
    (scan_fire && remove) |-> !ld_we) else $error("write port clash");
endmodule

// ----- sv/iterative_neighbor_erosion_unit.sv -----
// ----------------------------------------------------------------------------
// iterative_neighbor_erosion_unit
// Loads a binary image and erodes it by neighbour count until stable.
// ----------------------------------------------------------------------------
// Usage: cells arrive on the occupied request channel in raster order, one
// per cycle while the block is loading. The request completing the image
// starts the passes; input stall is high from the next cycle until the
// result is taken. In each pass every row is copied into the two-row
// window and then scanned against the next row, each through the single
// read port of the cell memory. Passes repeat until one removes nothing;
// then the tally is registered and one removed_total request is offered,
// and a stalled result holds. Reset clears the cursor, tally and sequencer;
// the cell memory is not cleared, as every cell read is written during the
// load. Config writes take effect at once; the user must make them while
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module iterative_neighbor_erosion_unit import ine_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic        occupied,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [16:0] removed_total,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT) > 0 ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1;
  localparam int XW = $clog2(MAX_WIDTH+1);
  localparam int YW = $clog2(MAX_HEIGHT+1);

  logic [8:0] grid_width, grid_height;
  logic [3:0] neighbor_threshold;
  logic [XW-1:0] w;
  logic [YW-1:0] h;
  logic [AW:0] cursor;
  logic busy, was_busy;
  logic [16:0] tally;
  eng_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 9'd256; grid_height <= 9'd256; neighbor_threshold <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:     grid_width <= cfg_data;
        REG_HEIGHT:    grid_height <= cfg_data;
        REG_THRESHOLD: neighbor_threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize clamps
  always_comb begin
    w = (grid_width == '0) ? XW'(1) :
        (32'(grid_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(grid_width);
    h = (grid_height == '0) ? YW'(1) :
        (32'(grid_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(grid_height);
  end

  logic acc;
  logic last;
  // held off while the engine runs, while the result is captured and offered
  assign stall_in = busy || was_busy || valid_out;
  assign acc = valid_in && !stall_in;
  assign last = 32'(cursor) + 1 >= 32'(w) * 32'(h);
  assign ctl.start = acc && last;
  assign ctl.busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0; valid_out <= 1'b0; was_busy <= 1'b0;
    end else begin
      was_busy <= busy;
      if (acc) cursor <= last ? '0 : cursor + 1'b1;
      if (was_busy && !busy) valid_out <= 1'b1;
      else if (valid_out && !stall_out) valid_out <= 1'b0;
    end
  end
  always_ff @(posedge clk) if (was_busy && !busy) removed_total <= tally;

  ine_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_eng (
    .clk, .rst, .ctl_in(ctl), .busy,
    .w, .h, .thr(neighbor_threshold),
    .ld_we(acc && cursor < (AW+1)'(MAX_WIDTH*MAX_HEIGHT)),
    .ld_addr(cursor[AW-1:0]), .ld_bit(occupied), .tally
  );

  assert property (@(posedge clk) disable iff (rst) busy |-> stall_in)
    else $error("request accepted during pass");
  assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("passes did not start");
  assert property (@(posedge clk) disable iff (rst)
    (valid_out && stall_out) |=> (valid_out && $stable(removed_total)))
    else $error("result lost under stall");
endmodule

// ----- test/iterative_neighbor_erosion_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_neighbor_erosion_unit_tb
// Streams binary images into the erosion unit and checks every removal count
// against a behavioural erosion model kept in the bench. Images are mostly
// small, with a few full-width and full-height strips; sizes, thresholds and
// fill density vary per image group; both channels idle at random at first.
// ----------------------------------------------------------------------------
module iterative_neighbor_erosion_unit_tb;
  import ine_pkg::*;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 256;
  localparam int LIMIT      = 20_000_000;
  localparam int DRAIN_WAIT = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid_in = 1'b0;
  logic        stall_in;
  logic        occupied = 1'b0;
  logic        valid_out;
  logic        stall_out = 1'b0;
  logic [16:0] removed_total;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [8:0]  cfg_data = '0;

  iterative_neighbor_erosion_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (valid_in),
    .stall_in     (stall_in),
    .occupied     (occupied),
    .valid_out    (valid_out),
    .stall_out    (stall_out),
    .removed_total(removed_total),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Erosion model: own copy of the registers, image and load cursor
  // --------------------------------------------------------------------------
  logic [8:0]  width_reg  = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [3:0]  thresh_reg = 4'd4;
  bit          image_cells [MAX_W*MAX_H];
  bit          pass_snap   [MAX_W*MAX_H];
  int unsigned load_pos = 0;

  logic        cell_queue [$];  // requests still to be driven
  logic [16:0] total_queue [$]; // removal counts still to arrive

  int unsigned errors = 0;
  int unsigned accepted_cells = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 55;
  bit          took_cell = 1'b0;

  function automatic int unsigned span(input logic [8:0] v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // runs passes until stable, reading only the start-of-pass snapshot
  function automatic int unsigned erode(input int unsigned w, input int unsigned h);
    int unsigned removed;
    int unsigned n;
    bit          changed;
    removed = 0;
    do begin
      changed = 1'b0;
      for (int unsigned i = 0; i < w*h; i++) pass_snap[i] = image_cells[i];
      for (int y = 0; y < int'(h); y++) begin
        for (int x = 0; x < int'(w); x++) begin
          if (pass_snap[y*w + x]) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++)
              for (int dx = -1; dx <= 1; dx++)
                if ((dx != 0 || dy != 0) && y+dy >= 0 && y+dy < int'(h) &&
                    x+dx >= 0 && x+dx < int'(w) && pass_snap[(y+dy)*w + x+dx])
                  n++;
            if (n < thresh_reg) begin
              image_cells[y*w + x] = 1'b0;
              removed++;
              changed = 1'b1;
            end
          end
        end
      end
    end while (changed);
    return removed;
  endfunction

  function automatic void load_cell(input logic b);
    int unsigned w;
    int unsigned h;
    w = span(width_reg, MAX_W);
    h = span(height_reg, MAX_H);
    image_cells[load_pos] = b;
    if (load_pos + 1 >= w*h) begin
      total_queue = {total_queue, 17'(erode(w, h))};
      load_pos = 0;
    end else begin
      load_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: accept on the rising edge, present new cells on the fall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    took_cell = !rst && valid_in && !stall_in;
    if (took_cell) begin
      load_cell(occupied);
      void'(cell_queue.pop_front());
      accepted_cells++;
    end
  end

  always @(negedge clk) begin
    // idle profile follows progress through the stimulus
    if (accepted_cells < 550) begin
      send_idle_pct = 12;
      recv_idle_pct = 55;
    end else if (accepted_cells < 1100) begin
      send_idle_pct = 55;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (!rst) begin
      // a stalled request holds; otherwise offer the next one or idle
      if (!(valid_in && !took_cell)) begin
        if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          valid_in <= 1'b1;
          occupied <= cell_queue[0];
        end else begin
          valid_in <= 1'b0;
        end
      end
      stall_out <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && valid_out && !stall_out) begin
      if (total_queue.size() == 0) begin
        $error("removed_total: unexpected result, actual %0d", removed_total);
        errors++;
      end else begin
        if (removed_total !== total_queue[0]) begin
          $error("removed_total: expected %0d, actual %0d", total_queue[0], removed_total);
          errors++;
        end
        void'(total_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[iterative_neighbor_erosion_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [8:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_WIDTH:     width_reg  = v;
      REG_HEIGHT:    height_reg = v;
      REG_THRESHOLD: thresh_reg = v[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one group of images at a fixed setting; returns once the unit is idle
  task automatic run_images(input logic [8:0] w, input logic [8:0] h, input logic [3:0] th,
                            input int unsigned count, input int unsigned fill_pct);
    int unsigned cells;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THRESHOLD, {5'd0, th});
    cells = span(w, MAX_W) * span(h, MAX_H);
    for (int unsigned k = 0; k < count * cells; k++)
      cell_queue = {cell_queue, logic'($urandom_range(99) < fill_pct)};
    while (cell_queue.size() > 0 || total_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [8:0] w;
    logic [8:0] h;
    logic [3:0] th;
    int unsigned pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: solid block, zero sizes, zero and oversize thresholds
    run_images(9'd3, 9'd3, 4'd4, 1, 100);
    run_images(9'd0, 9'd0, 4'd0, 2, 50);
    run_images(9'd0, 9'd1, 4'd1, 2, 100);
    run_images(9'd2, 9'd2, 4'd0, 1, 100);
    run_images(9'd2, 9'd2, 4'd15, 1, 100);
    run_images(9'd2, 9'd2, 4'd9, 1, 100);
    run_images(9'd2, 9'd2, 4'd3, 1, 100);

    // random: mostly small images, a few full-size strips
    while (accepted_cells < 1650) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        w = ($urandom_range(1)) ? 9'd256 : 9'd511;
        h = 9'($urandom_range(2));
      end else if (pick < 8) begin
        w = 9'($urandom_range(2));
        h = ($urandom_range(1)) ? 9'd256 : 9'd300 + 9'($urandom_range(211));
      end else begin
        w = 9'($urandom_range(10));
        h = 9'($urandom_range(10));
      end
      th = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6, 2));
      run_images(w, h, th, $urandom_range(3, 1), $urandom_range(100));
    end

    if (total_queue.size() != 0) begin
      $error("removed_total: %0d results never arrived", total_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[iterative_neighbor_erosion_unit] OK");
    end else begin
      $display("[iterative_neighbor_erosion_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- iterative_neighbor_erosion_unit.f -----
sv/ine_pkg.sv
sv/ine_engine.sv
sv/iterative_neighbor_erosion_unit.sv
test/iterative_neighbor_erosion_unit_tb.sv
